FILE: rtl/core/csc_pkg.sv
package csc_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int NORM_W     = 16;
    localparam int NORM_FRAC  = 14;
    localparam int SUM_W      = 67;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_A        = 2'd1,
        REGION_B        = 2'd2
    } region_t;

    // classified pair handed from front to back
    typedef struct packed {
        region_t              region;
        logic signed [31:0]   px;      // endpoint for end regions, A for interior
        logic signed [31:0]   py;
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
        logic [30:0]          r;
        logic [32:0]          ex_mag;
        logic [32:0]          ey_mag;
        logic                 ex_neg;
        logic                 ey_neg;
        logic [SUM_W-1:0]     dot;
        logic [SUM_W-1:0]     len2;
    } item_t;

    typedef struct packed {
        logic                 hit;
        logic signed [31:0]   contact_x;
        logic signed [31:0]   contact_y;
        logic signed [15:0]   normal_x;
        logic signed [15:0]   normal_y;
        logic [30:0]          depth;
        region_t              region;
    } res_t;

endpackage

FILE: rtl/core/csc_front.sv
module csc_front
    import csc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] cy,
    input  logic [30:0]        rad,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    output logic               out_valid,
    input  logic               out_ready,
    output item_t              out_item
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: differences
    logic signed [32:0] dx1_reg, dy1_reg, ex1_reg, ey1_reg;
    logic signed [31:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic [30:0]        r1_reg;

    // stage 2: products
    logic signed [65:0] exsq_next, eysq_next, dxe_next, dye_next;
    logic signed [65:0] exsq2_reg, eysq2_reg, dxe2_reg, dye2_reg;
    logic [32:0]        exm2_reg, eym2_reg;
    logic               exn2_reg, eyn2_reg;
    logic signed [31:0] ax2_reg, ay2_reg, bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic [30:0]        r2_reg;

    // stage 3: sums
    logic [66:0]        len2_3_reg;
    logic signed [66:0] dot_3_reg;
    logic [32:0]        exm3_reg, eym3_reg;
    logic               exn3_reg, eyn3_reg;
    logic signed [31:0] ax3_reg, ay3_reg, bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic [30:0]        r3_reg;

    item_t item_next, item_reg;

    assign adv       = !v4_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v4_reg;
    assign out_item  = item_reg;

    assign exsq_next = ex1_reg * ex1_reg;
    assign eysq_next = ey1_reg * ey1_reg;
    assign dxe_next  = dx1_reg * ex1_reg;
    assign dye_next  = dy1_reg * ey1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx1_reg <= {cx[31], cx} - {ax[31], ax};
            dy1_reg <= {cy[31], cy} - {ay[31], ay};
            ex1_reg <= {bx[31], bx} - {ax[31], ax};
            ey1_reg <= {by[31], by} - {ay[31], ay};
            ax1_reg <= ax;
            ay1_reg <= ay;
            bx1_reg <= bx;
            by1_reg <= by;
            cx1_reg <= cx;
            cy1_reg <= cy;
            r1_reg  <= rad;

            exsq2_reg <= exsq_next;
            eysq2_reg <= eysq_next;
            dxe2_reg  <= dxe_next;
            dye2_reg  <= dye_next;
            exm2_reg  <= ex1_reg[32] ? 33'(33'd0 - ex1_reg) : 33'(ex1_reg);
            eym2_reg  <= ey1_reg[32] ? 33'(33'd0 - ey1_reg) : 33'(ey1_reg);
            exn2_reg  <= ex1_reg[32];
            eyn2_reg  <= ey1_reg[32];
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            r2_reg    <= r1_reg;

            len2_3_reg <= {1'b0, exsq2_reg[65:0]} + {1'b0, eysq2_reg[65:0]};
            dot_3_reg  <= {dxe2_reg[65], dxe2_reg} + {dye2_reg[65], dye2_reg};
            exm3_reg   <= exm2_reg;
            eym3_reg   <= eym2_reg;
            exn3_reg   <= exn2_reg;
            eyn3_reg   <= eyn2_reg;
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
            bx3_reg    <= bx2_reg;
            by3_reg    <= by2_reg;
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            r3_reg     <= r2_reg;

            item_reg <= item_next;
        end
    end

    // region choice: degenerate or behind A, past B, else interior
    always_comb begin
        item_next.cx     = cx3_reg;
        item_next.cy     = cy3_reg;
        item_next.r      = r3_reg;
        item_next.ex_mag = exm3_reg;
        item_next.ey_mag = eym3_reg;
        item_next.ex_neg = exn3_reg;
        item_next.ey_neg = eyn3_reg;
        item_next.dot    = dot_3_reg;
        item_next.len2   = len2_3_reg;
        if (len2_3_reg == '0 || dot_3_reg[66]) begin
            item_next.region = REGION_A;
            item_next.px     = ax3_reg;
            item_next.py     = ay3_reg;
        end else if ($unsigned(dot_3_reg) > len2_3_reg) begin
            item_next.region = REGION_B;
            item_next.px     = bx3_reg;
            item_next.py     = by3_reg;
        end else begin
            item_next.region = REGION_INTERIOR;
            item_next.px     = ax3_reg;
            item_next.py     = ay3_reg;
        end
    end

endmodule

FILE: rtl/core/csc_queue.sv
module csc_queue
    import csc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = count_reg != FULL_CNT;
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/csc_back.sv
module csc_back
    import csc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int NUM_W = 101;   // |e| * dot plus half of len2
    localparam int OQ_W  = 33;    // projected offset bits
    localparam int SQ_N  = 31;    // root bits
    localparam int NN_W  = 48;    // normal numerator
    localparam int NQ_W  = 15;    // normal quotient bits

    typedef struct packed {
        logic                 hit;
        region_t              region;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic [30:0]          r;
        logic [32:0]          nxm;
        logic [32:0]          nym;
        logic                 nxn;
        logic                 nyn;
        logic [61:0]          d2;
    } geo_t;

    typedef struct packed {
        logic                 hit;
        region_t              region;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic [30:0]          depth;
        logic                 zero;
        logic                 nxn;
        logic                 nyn;
        logic [31:0]          s;
    } nrm_t;

    logic adv;

    // projection products
    logic        vb1_reg;
    item_t       itb1_reg;
    logic [66:0] plx_reg, ply_reg;
    logic [65:0] phx_reg, phy_reg;

    // offset divider chain, index 0 is its input
    logic              dv_v  [0:OQ_W];
    item_t             dv_it [0:OQ_W];
    logic [NUM_W-1:0]  dv_rx [0:OQ_W];
    logic [NUM_W-1:0]  dv_ry [0:OQ_W];
    logic [OQ_W-1:0]   dv_qx [0:OQ_W];
    logic [OQ_W-1:0]   dv_qy [0:OQ_W];

    // contact point, offsets, squares
    logic               vb3_reg, vb4_reg, vb5_reg, vb6_reg;
    item_t              it_last;
    logic signed [33:0] offx, offy;
    logic signed [31:0] px3_reg, py3_reg, cx3_reg, cy3_reg;
    logic [30:0]        r3_reg, r4_reg, r5_reg;
    region_t            rg3_reg, rg4_reg, rg5_reg;
    logic signed [31:0] px4_reg, py4_reg, px5_reg, py5_reg;
    logic signed [32:0] nx4_reg, ny4_reg;
    logic [61:0]        rr4_reg, rr5_reg;
    logic signed [65:0] nxsq, nysq;
    logic [65:0]        nxsq5_reg, nysq5_reg;
    logic [32:0]        nxm5_reg, nym5_reg;
    logic               nxn5_reg, nyn5_reg;
    logic [66:0]        dist2;
    geo_t               geo6_reg;

    // square root chain
    logic        sq_v    [0:SQ_N];
    geo_t        sq_g    [0:SQ_N];
    logic [32:0] sq_rem  [0:SQ_N];
    logic [30:0] sq_root [0:SQ_N];

    // rounding and normal numerators
    logic        vr1_reg, vr2_reg;
    geo_t        gr1_reg;
    logic [31:0] s1_reg;
    nrm_t        nr2_reg;
    logic [NN_W-1:0] nnx2_reg, nny2_reg;

    // normal divider chain
    logic            nd_v  [0:NQ_W];
    nrm_t            nd_p  [0:NQ_W];
    logic [NN_W-1:0] nd_rx [0:NQ_W];
    logic [NN_W-1:0] nd_ry [0:NQ_W];
    logic [NQ_W-1:0] nd_qx [0:NQ_W];
    logic [NQ_W-1:0] nd_qy [0:NQ_W];

    logic  vout_reg;
    res_t  res_next, res_reg;

    assign adv       = !vout_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = vout_reg;
    assign out_res   = res_reg;

    // ---------------- projection numerators ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb1_reg  <= 1'b0;
            dv_v[0]  <= 1'b0;
        end else if (adv) begin
            vb1_reg  <= in_valid;
            dv_v[0]  <= vb1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            itb1_reg <= in_item;
            plx_reg  <= 67'(in_item.ex_mag) * 67'(in_item.dot[33:0]);
            ply_reg  <= 67'(in_item.ey_mag) * 67'(in_item.dot[33:0]);
            phx_reg  <= 66'(in_item.ex_mag) * 66'(in_item.dot[66:34]);
            phy_reg  <= 66'(in_item.ey_mag) * 66'(in_item.dot[66:34]);
            dv_it[0] <= itb1_reg;
            dv_rx[0] <= NUM_W'(plx_reg) + (NUM_W'(phx_reg) << 34)
                        + NUM_W'(itb1_reg.len2 >> 1);
            dv_ry[0] <= NUM_W'(ply_reg) + (NUM_W'(phy_reg) << 34)
                        + NUM_W'(itb1_reg.len2 >> 1);
            dv_qx[0] <= '0;
            dv_qy[0] <= '0;
        end
    end

    // ---------------- offset divider, one quotient bit a stage ----------------
    for (genvar j = 1; j <= OQ_W; j++) begin : g_odiv
        localparam int SH = OQ_W - j;
        logic [NUM_W-1:0] dd;
        logic             gex, gey;
        assign dd  = NUM_W'(dv_it[j-1].len2) << SH;
        assign gex = dv_rx[j-1] >= dd;
        assign gey = dv_ry[j-1] >= dd;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v[j] <= 1'b0;
            end else if (adv) begin
                dv_v[j] <= dv_v[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_it[j] <= dv_it[j-1];
                dv_rx[j] <= gex ? dv_rx[j-1] - dd : dv_rx[j-1];
                dv_ry[j] <= gey ? dv_ry[j-1] - dd : dv_ry[j-1];
                dv_qx[j] <= dv_qx[j-1] | (OQ_W'(gex) << SH);
                dv_qy[j] <= dv_qy[j-1] | (OQ_W'(gey) << SH);
            end
        end
    end

    // ---------------- contact point and distance ----------------
    assign it_last = dv_it[OQ_W];
    assign offx = it_last.ex_neg ? 34'sd0 - $signed({1'b0, dv_qx[OQ_W]})
                                 : $signed({1'b0, dv_qx[OQ_W]});
    assign offy = it_last.ey_neg ? 34'sd0 - $signed({1'b0, dv_qy[OQ_W]})
                                 : $signed({1'b0, dv_qy[OQ_W]});
    assign nxsq  = nx4_reg * nx4_reg;
    assign nysq  = ny4_reg * ny4_reg;
    assign dist2 = {1'b0, nxsq5_reg} + {1'b0, nysq5_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb3_reg  <= 1'b0;
            vb4_reg  <= 1'b0;
            vb5_reg  <= 1'b0;
            vb6_reg  <= 1'b0;
        end else if (adv) begin
            vb3_reg  <= dv_v[OQ_W];
            vb4_reg  <= vb3_reg;
            vb5_reg  <= vb4_reg;
            vb6_reg  <= vb5_reg;
        end
    end

    assign sq_v[0] = vb6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (it_last.region == REGION_INTERIOR) begin
                px3_reg <= 32'({it_last.px[31], it_last.px[31], it_last.px} + offx);
                py3_reg <= 32'({it_last.py[31], it_last.py[31], it_last.py} + offy);
            end else begin
                px3_reg <= it_last.px;
                py3_reg <= it_last.py;
            end
            cx3_reg <= it_last.cx;
            cy3_reg <= it_last.cy;
            r3_reg  <= it_last.r;
            rg3_reg <= it_last.region;

            nx4_reg <= {px3_reg[31], px3_reg} - {cx3_reg[31], cx3_reg};
            ny4_reg <= {py3_reg[31], py3_reg} - {cy3_reg[31], cy3_reg};
            rr4_reg <= 62'(r3_reg) * 62'(r3_reg);
            px4_reg <= px3_reg;
            py4_reg <= py3_reg;
            r4_reg  <= r3_reg;
            rg4_reg <= rg3_reg;

            nxsq5_reg <= nxsq[65:0];
            nysq5_reg <= nysq[65:0];
            nxm5_reg  <= nx4_reg[32] ? 33'(33'd0 - nx4_reg) : 33'(nx4_reg);
            nym5_reg  <= ny4_reg[32] ? 33'(33'd0 - ny4_reg) : 33'(ny4_reg);
            nxn5_reg  <= nx4_reg[32];
            nyn5_reg  <= ny4_reg[32];
            rr5_reg   <= rr4_reg;
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            r5_reg    <= r4_reg;
            rg5_reg   <= rg4_reg;

            geo6_reg.hit    <= dist2 <= SUM_W'(rr5_reg);
            geo6_reg.region <= rg5_reg;
            geo6_reg.px     <= px5_reg;
            geo6_reg.py     <= py5_reg;
            geo6_reg.r      <= r5_reg;
            geo6_reg.nxm    <= nxm5_reg;
            geo6_reg.nym    <= nym5_reg;
            geo6_reg.nxn    <= nxn5_reg;
            geo6_reg.nyn    <= nyn5_reg;
            geo6_reg.d2     <= dist2[61:0];
        end
    end

    assign sq_g[0]    = geo6_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // ---------------- square root, one root bit a stage ----------------
    for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
        localparam int PI = SQ_N - k;
        logic [34:0] cur, trial;
        logic        take;
        assign cur   = {sq_rem[k-1], sq_g[k-1].d2[2*PI+1 -: 2]};
        assign trial = 35'({sq_root[k-1], 2'b01});
        assign take  = cur >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v[k] <= 1'b0;
            end else if (adv) begin
                sq_v[k] <= sq_v[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_g[k]    <= sq_g[k-1];
                sq_rem[k]  <= take ? 33'(cur - trial) : cur[32:0];
                sq_root[k] <= {sq_root[k-1][29:0], take};
            end
        end
    end

    // ---------------- rounding, depth, normal numerators ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr1_reg <= 1'b0;
            vr2_reg <= 1'b0;
        end else if (adv) begin
            vr1_reg <= sq_v[SQ_N];
            vr2_reg <= vr1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gr1_reg <= sq_g[SQ_N];
            s1_reg  <= 32'(sq_root[SQ_N])
                       + 32'(sq_rem[SQ_N] > 33'(sq_root[SQ_N]));

            nr2_reg.hit    <= gr1_reg.hit;
            nr2_reg.region <= gr1_reg.region;
            nr2_reg.px     <= gr1_reg.px;
            nr2_reg.py     <= gr1_reg.py;
            nr2_reg.depth  <= gr1_reg.r - s1_reg[30:0];
            nr2_reg.zero   <= s1_reg == '0;
            nr2_reg.nxn    <= gr1_reg.nxn;
            nr2_reg.nyn    <= gr1_reg.nyn;
            nr2_reg.s      <= s1_reg;
            nnx2_reg <= (NN_W'(gr1_reg.nxm) << NORM_FRAC) + NN_W'(s1_reg >> 1);
            nny2_reg <= (NN_W'(gr1_reg.nym) << NORM_FRAC) + NN_W'(s1_reg >> 1);
        end
    end

    assign nd_v[0]  = vr2_reg;
    assign nd_p[0]  = nr2_reg;
    assign nd_rx[0] = nnx2_reg;
    assign nd_ry[0] = nny2_reg;
    assign nd_qx[0] = '0;
    assign nd_qy[0] = '0;

    // ---------------- normal divider, one quotient bit a stage ----------------
    for (genvar m = 1; m <= NQ_W; m++) begin : g_ndiv
        localparam int SH = NQ_W - m;
        logic [NN_W-1:0] dd;
        logic            gex, gey;
        assign dd  = NN_W'(nd_p[m-1].s) << SH;
        assign gex = nd_rx[m-1] >= dd;
        assign gey = nd_ry[m-1] >= dd;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nd_v[m] <= 1'b0;
            end else if (adv) begin
                nd_v[m] <= nd_v[m-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                nd_p[m]  <= nd_p[m-1];
                nd_rx[m] <= gex ? nd_rx[m-1] - dd : nd_rx[m-1];
                nd_ry[m] <= gey ? nd_ry[m-1] - dd : nd_ry[m-1];
                nd_qx[m] <= nd_qx[m-1] | (NQ_W'(gex) << SH);
                nd_qy[m] <= nd_qy[m-1] | (NQ_W'(gey) << SH);
            end
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        res_next        = '0;
        res_next.region = nd_p[NQ_W].region;
        if (nd_p[NQ_W].hit) begin
            res_next.hit       = 1'b1;
            res_next.contact_x = nd_p[NQ_W].px;
            res_next.contact_y = nd_p[NQ_W].py;
            res_next.depth     = nd_p[NQ_W].depth;
            if (!nd_p[NQ_W].zero) begin
                res_next.normal_x = nd_p[NQ_W].nxn ? 16'sd0 - $signed({1'b0, nd_qx[NQ_W]})
                                                   : $signed({1'b0, nd_qx[NQ_W]});
                res_next.normal_y = nd_p[NQ_W].nyn ? 16'sd0 - $signed({1'b0, nd_qy[NQ_W]})
                                                   : $signed({1'b0, nd_qy[NQ_W]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
        end else if (adv) begin
            vout_reg <= nd_v[NQ_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/core/circle_segment_contact.sv
// Circle against line segment contact test. One circle and one segment come in
// per request on the slave stream and exactly one result leaves per request on
// the master stream, in order. A new request is taken every clock cycle while
// the output side keeps up; the rate is set by the fully pipelined datapath,
// where the projection divider, the square root and the normal dividers each
// resolve one bit per stage. An accepted request passes through four front
// stages that compute the projection terms and pick the region (interior,
// endpoint A or endpoint B), a small queue, then the back pipeline of 88
// stages. The queue lets the front keep accepting while the back is held by
// m_tready. A zero length segment is tested as endpoint A, and a contact point
// that sits on the centre gives a zero normal. On a miss every result field is
// zero except the region.
module circle_segment_contact
    import csc_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x[31:0] center_y[63:32] circle_radius[94:64] seg_ax[126:95]
    // seg_ay[158:127] seg_bx[190:159] seg_by[222:191], bit 223 zero
    input  logic [223:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // contact_x[31:0] contact_y[63:32] normal_x[79:64] normal_y[95:80]
    // depth[126:96], bit 127 zero
    output logic [127:0] m_tdata,
    // hit[0] contact_region[2:1]
    output logic [2:0]   m_tuser
);

    // front to queue
    logic  f_valid, f_ready;
    item_t f_item;

    // queue to back
    logic  q_valid, q_ready;
    item_t q_item;

    res_t  res;

    csc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cx        (s_tdata[31:0]),
        .cy        (s_tdata[63:32]),
        .rad       (s_tdata[94:64]),
        .ax        (s_tdata[126:95]),
        .ay        (s_tdata[158:127]),
        .bx        (s_tdata[190:159]),
        .by        (s_tdata[222:191]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // decouples classification from the long arithmetic pipeline
    csc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    csc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // result packing
    assign m_tdata = {1'b0, res.depth, res.normal_y, res.normal_x,
                      res.contact_y, res.contact_x};
    assign m_tuser = {res.region, res.hit};

endmodule
